FILE: hdl/ptrq_pkg.sv
package ptrq_pkg;

  // One table entry as it sits in a cell.
  typedef struct packed {
    logic [15:0]        tag;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROT,
    CELL_DROP
  } cell_op_t;

  // A query match on its way to the result register.
  typedef struct packed {
    logic [15:0] tag;
    logic        exact;
  } hit_t;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_DEL_TAG,
    KIND_DEL_POS,
    KIND_QUERY
  } kind_t;

  // Status codes carried by a result beat.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

endpackage

FILE: hdl/ptrq_in_if.sv
interface ptrq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        tag;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [16:0]        radius;

  modport source (output valid, kind, tag, pos_x, pos_y, radius, input ready);
  modport sink (input valid, kind, tag, pos_x, pos_y, radius, output ready);
endinterface

FILE: hdl/ptrq_out_if.sv
interface ptrq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hit_tag;
  logic        hit_valid;
  logic        hit_exact;
  logic [1:0]  status;
  logic [5:0]  entries_held;
  logic        last;

  modport source (output valid, hit_tag, hit_valid, hit_exact, status, entries_held, last,
                  input ready);
  modport sink (input valid, hit_tag, hit_valid, hit_exact, status, entries_held, last,
                output ready);
endinterface

FILE: hdl/ptrq_cell.sv
module ptrq_cell #(
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ptrq_pkg::cell_op_t op,
  input  logic [CW-1:0]     cnt,
  input  logic [CW-1:0]     mcnt,
  input  ptrq_pkg::entry_t  ins,
  input  ptrq_pkg::entry_t  right,
  input  ptrq_pkg::entry_t  wrap,
  input  ptrq_pkg::entry_t  back,
  output ptrq_pkg::entry_t  q
);
  import ptrq_pkg::*;

  localparam logic [CW-1:0] POS_C  = CW'(IDX);
  localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

  // Load, rotate the filled part as a ring, or close a gap left by a removal.
  // During a removal scan the unscanned entries sit in cells below mcnt and the
  // kept ones above them; a dropped front entry is replaced by the unscanned back.
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LOAD: begin
        if (cnt == POS_C) q <= ins;
      end
      CELL_ROT: begin
        if (NEXT_C < cnt) q <= right;
        else if (NEXT_C == cnt) q <= wrap;
      end
      CELL_DROP: begin
        if (NEXT_C >= mcnt && NEXT_C < cnt) q <= right;
        else if (IDX == 0) q <= back;
      end
      CELL_HOLD: begin
        q <= q;
      end
    endcase
  end

endmodule

FILE: hdl/ptrq_chain.sv
module ptrq_chain #(
  parameter int CAPACITY = 32,
  parameter int CW       = 6
) (
  input  logic              clk,
  input  ptrq_pkg::cell_op_t op,
  input  logic [CW-1:0]     cnt,
  input  logic [CW-1:0]     mcnt,
  input  ptrq_pkg::entry_t  ins,
  output ptrq_pkg::entry_t  head
);
  import ptrq_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  entry_t        q [CAPACITY];
  entry_t        back;
  logic [CW-1:0] back_ix;

  // The back of the unscanned part feeds cell zero when its entry is dropped.
  assign back_ix = mcnt - CW'(1);
  assign back    = q[back_ix[IW-1:0]];
  assign head    = q[0];

  // Each cell takes its right neighbor when the ring turns.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t right_k;
    if (k == CAPACITY - 1) begin : g_end
      assign right_k = q[k];
    end else begin : g_mid
      assign right_k = q[k+1];
    end
    ptrq_cell #(.CW(CW), .IDX(k)) u_cell (
      .clk   (clk),
      .op    (op),
      .cnt   (cnt),
      .mcnt  (mcnt),
      .ins   (ins),
      .right (right_k),
      .wrap  (q[0]),
      .back  (back),
      .q     (q[k])
    );
  end

endmodule

FILE: hdl/ptrq_dist.sv
module ptrq_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               issue,
  input  logic               skip_in,
  input  logic               load_r2,
  input  ptrq_pkg::entry_t   head,
  input  logic signed [15:0] cx,
  input  logic signed [15:0] cy,
  input  logic [16:0]        radius,
  output logic               hit,
  output ptrq_pkg::hit_t     hit_info
);
  import ptrq_pkg::*;

  logic [33:0]        r2_r;
  logic [33:0]        rad_ext;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] sqx_full;
  logic signed [33:0] sqy_full;
  logic [31:0]        sq_x_r;
  logic [31:0]        sq_y_r;
  logic [32:0]        d2;
  hit_t               info_r;
  logic               skip_r;
  logic               vld_r;

  // Radius squared, formed during the exact-match pass.
  assign rad_ext = 34'(radius);
  always_ff @(posedge clk) begin
    if (load_r2) r2_r <= rad_ext * rad_ext;
  end

  // Offsets from the centre and their squares for the entry in cell zero.
  assign dx       = {head.x[15], head.x} - {cx[15], cx};
  assign dy       = {head.y[15], head.y} - {cy[15], cy};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r        <= issue;
      skip_r       <= skip_in;
      sq_x_r       <= sqx_full[31:0];
      sq_y_r       <= sqy_full[31:0];
      info_r.tag   <= head.tag;
      info_r.exact <= (head.x == cx) && (head.y == cy);
    end
  end

  // Sum of squares against the limit.
  assign d2       = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign hit      = vld_r && !skip_r && ({1'b0, d2} <= r2_r);
  assign hit_info = info_r;

endmodule

FILE: hdl/point_table_radius_query_unit.sv
// Table of up to CAPACITY named points with insert, removal and radius query.
// Input channel in_ch: one beat is one operation (kind, tag, pos_x, pos_y,
// radius). Result channel out_ch: insert and removals give one beat each, a
// query gives one beat per match (the first exact match first, then the rest
// in table order) or a single empty beat; the last beat of an operation has
// last set, and every beat carries the entry count after the operation.
// A new operation is taken only when the previous one has handed its final
// beat to the output register, so a waiting result never blocks acceptance.
// The table rotates one cell per cycle, unless a query is stalled, past the
// comparators at cell zero: once for a removal and twice for a query
// (exact-match search, then the distance pass through one squaring stage).
// An insert with room loads the cell at the end of the filled part, and a
// removal or query on an empty table goes straight to the final beat. Every
// final beat is registered as the unit returns to idle.
// Reset empties the table and clears the output valid flag; entry contents
// are not cleared. A stalled receiver holds the output register, and a query
// freezes its rotation until the pending match can move on.
module point_table_radius_query_unit #(
  parameter int CAPACITY = 32
) (
  input logic       clk,
  input logic       rst_n,
  ptrq_in_if.sink   in_ch,
  ptrq_out_if.source out_ch
);
  import ptrq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_QP1,
    S_QP2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] hit_tag;
    logic        hit_valid;
    logic        hit_exact;
    logic [1:0]  status;
    logic [5:0]  entries_held;
    logic        last;
  } result_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      m_r;
  logic [CW-1:0]      s_r;
  logic [CW-1:0]      fidx_r;
  logic               found_r;
  logic [1:0]         st_r;
  logic [1:0]         kind_r;
  logic [15:0]        tag_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic [16:0]        radius_r;
  hit_t               pend_r;
  logic               pend_v_r;
  result_t            out_r;
  logic               out_valid_r;

  entry_t             head;
  entry_t             ins;
  cell_op_t           cell_op;
  logic               front_match;
  logic               exact_head;
  logic               o_free;
  logic               out_load;
  logic               hit;
  hit_t               hit_info;
  logic               stall;
  logic [CW+5:0]      cnt_ext;
  logic [5:0]         held;
  result_t            mid_res;
  result_t            fin_res;

  assign ins = '{tag: tag_r, x: x_r, y: y_r};

  // Comparisons on the entry at the head of the chain.
  assign exact_head  = (head.x == x_r) && (head.y == y_r);
  assign front_match = (kind_r == KIND_DEL_TAG) ? (head.tag == tag_r) : exact_head;

  // A match can move on only if the output register is free or being emptied.
  assign o_free = !out_valid_r || out_ch.ready;
  assign stall  = hit && pend_v_r && !o_free;

  // The output register takes a new beat in this cycle.
  assign out_load = (state_r == S_QP2 && !stall && hit && pend_v_r) ||
                    (state_r == S_FIN && o_free);

  assign cnt_ext = {6'b0, cnt_r};
  assign held    = cnt_ext[5:0];

  // Beat for a match that another match has followed.
  always_comb begin
    mid_res              = '0;
    mid_res.hit_tag      = pend_r.tag;
    mid_res.hit_valid    = 1'b1;
    mid_res.hit_exact    = pend_r.exact;
    mid_res.status       = ST_OK;
    mid_res.entries_held = held;
    mid_res.last         = 1'b0;
  end

  // Final beat of an operation.
  always_comb begin
    fin_res              = '0;
    fin_res.status       = st_r;
    fin_res.entries_held = held;
    fin_res.last         = 1'b1;
    if (kind_r == KIND_QUERY && pend_v_r) begin
      fin_res.hit_tag   = pend_r.tag;
      fin_res.hit_valid = 1'b1;
      fin_res.hit_exact = pend_r.exact;
    end
  end

  // Command to the cells.
  always_comb begin
    cell_op = CELL_HOLD;
    unique case (state_r)
      S_INS: begin
        if (cnt_r < CAP_C) cell_op = CELL_LOAD;
      end
      S_REM: begin
        cell_op = front_match ? CELL_DROP : CELL_ROT;
      end
      S_QP1: begin
        cell_op = CELL_ROT;
      end
      S_QP2: begin
        if (!stall && s_r != cnt_r) cell_op = CELL_ROT;
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  ptrq_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_chain (
    .clk  (clk),
    .op   (cell_op),
    .cnt  (cnt_r),
    .mcnt (m_r),
    .ins  (ins),
    .head (head)
  );

  ptrq_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (state_r == S_QP2 && !stall),
    .issue    (s_r != cnt_r),
    .skip_in  (found_r && s_r == fidx_r),
    .load_r2  (state_r == S_QP1),
    .head     (head),
    .cx       (x_r),
    .cy       (y_r),
    .radius   (radius_r),
    .hit      (hit),
    .hit_info (hit_info)
  );

  // Sequencer, pending match and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r   <= in_ch.kind;
            tag_r    <= in_ch.tag;
            x_r      <= in_ch.pos_x;
            y_r      <= in_ch.pos_y;
            radius_r <= in_ch.radius;
            m_r      <= cnt_r;
            s_r      <= '0;
            found_r  <= 1'b0;
            pend_v_r <= 1'b0;
            st_r     <= (in_ch.kind == KIND_DEL_TAG || in_ch.kind == KIND_DEL_POS) ?
                        ST_NOMATCH : ST_OK;
            unique case (in_ch.kind)
              KIND_INSERT: state_r <= S_INS;
              KIND_DEL_TAG, KIND_DEL_POS: state_r <= (cnt_r == '0) ? S_FIN : S_REM;
              KIND_QUERY: state_r <= (cnt_r == '0) ? S_FIN : S_QP1;
            endcase
          end
        end
        S_INS: begin
          if (cnt_r < CAP_C) cnt_r <= cnt_r + ONE_C;
          else st_r <= ST_FULL;
          state_r <= S_FIN;
        end
        S_REM: begin
          m_r <= m_r - ONE_C;
          if (front_match) begin
            cnt_r <= cnt_r - ONE_C;
            st_r  <= ST_OK;
          end
          if (m_r == ONE_C) state_r <= S_FIN;
        end
        S_QP1: begin
          if (exact_head && !found_r) begin
            found_r      <= 1'b1;
            fidx_r       <= s_r;
            pend_r.tag   <= head.tag;
            pend_r.exact <= 1'b1;
            pend_v_r     <= 1'b1;
          end
          if (s_r + ONE_C == cnt_r) begin
            s_r     <= '0;
            state_r <= S_QP2;
          end else begin
            s_r <= s_r + ONE_C;
          end
        end
        S_QP2: begin
          if (!stall) begin
            if (s_r != cnt_r) s_r <= s_r + ONE_C;
            else state_r <= S_FIN;
            if (hit) begin
              if (pend_v_r) begin
                out_r       <= mid_res;
                out_valid_r <= 1'b1;
              end
              pend_r   <= hit_info;
              pend_v_r <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (o_free) begin
            out_r       <= fin_res;
            out_valid_r <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit_tag      = out_r.hit_tag;
  assign out_ch.hit_valid    = out_r.hit_valid;
  assign out_ch.hit_exact    = out_r.hit_exact;
  assign out_ch.status       = out_r.status;
  assign out_ch.entries_held = out_r.entries_held;
  assign out_ch.last         = out_r.last;

endmodule
